// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define AST_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset
`define AST_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ffca_pkg.sv =====
// Types, codes and defaults of the first-fit chunk allocator
package ffca_pkg;

  localparam int SLAB_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int ALIGN_BYTES_DEF  = 32;
  localparam int MAX_CHUNKS_DEF   = 2048;

  localparam int LEN_W  = 16;
  localparam int REQ_W  = 17;
  localparam int SIZE_W = 18;
  localparam int OFF_W  = 16;
  localparam int BYTE_W = 32;
  localparam int ACT_W  = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ALLOC_FAIL = 2'd1,
    STAT_BAD_FREE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EX,
    ST_NEXT_RD,
    ST_NEXT_EX,
    ST_FIX,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WB1,
    ST_WB2,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             act;
  } entry_t;

endpackage

// ===== hdl/first_fit_chunk_allocator_unit.sv =====
// A disabled or zero-length alloc goes straight to the result; else a walk reads each chunk entry;
// a miss or a free of a free chunk ends there; a hit reads the next entry, shifts, then writes back.
// Throughput: one transaction at a time; the table walk through the table memory sets it.
// The result register frees the input side while a result waits to be taken.
// Reset: synchronous, active low; after reset the ST_INIT state writes the initial chunk, stall held.
// Configuration: enable at byte address 0, reset value 1.
`include "assert_macros.svh"

module first_fit_chunk_allocator_unit #(
  parameter int SLAB_BYTES   = ffca_pkg::SLAB_BYTES_DEF,
  parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffca_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_CHUNKS   = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [ffca_pkg::REQ_W-1:0]   in_req_length,
  input  logic [ffca_pkg::OFF_W-1:0]   in_free_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [ffca_pkg::OFF_W-1:0]   out_payload_offset,
  output logic [ffca_pkg::BYTE_W-1:0]  out_bytes_in_use,
  output logic [ffca_pkg::ACT_W-1:0]   out_chunks_in_use,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ffca_pkg::*;

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = IW + 1;
  localparam int HW = $clog2(SLAB_BYTES) + 1;
  localparam logic [SIZE_W-1:0] ALIGN_M1 = SIZE_W'(ALIGN_BYTES - 1);
  localparam logic [LEN_W-1:0]  HDR_L    = LEN_W'(HEADER_BYTES);
  localparam logic [HW-1:0]     HDR_H    = HW'(HEADER_BYTES);
  localparam logic [LEN_W-1:0]  INIT_LEN = LEN_W'(SLAB_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0]     MAXC     = CW'(MAX_CHUNKS);
  localparam logic [CW-1:0]     ONE_C    = CW'(1);

  st_t state_r, state_nxt;

  logic                enable_r, enable_nxt;
  logic                cmd_r, cmd_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       count_new_r, count_new_nxt;
  logic [HW-1:0]       hdr_r, hdr_nxt;
  logic [LEN_W-1:0]    prev_len_r, prev_len_nxt;
  logic                prev_act_r, prev_act_nxt;
  logic [LEN_W-1:0]    hit_len_r, hit_len_nxt;
  logic                next_free_r, next_free_nxt;
  logic [LEN_W-1:0]    next_len_r, next_len_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  status_t             stat_r, stat_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [CW-1:0]       sh_src_r, sh_src_nxt;
  logic [CW-1:0]       sh_dst_r, sh_dst_nxt;
  logic                sh_dn_r, sh_dn_nxt;
  logic [CW-1:0]       w1_addr_r, w1_addr_nxt;
  entry_t              w1_data_r, w1_data_nxt;
  logic [CW-1:0]       w2_addr_r, w2_addr_nxt;
  entry_t              w2_data_r, w2_data_nxt;
  logic                w2_en_r, w2_en_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_stat_r, out_stat_nxt;
  logic [OFF_W-1:0]    out_off_r, out_off_nxt;
  logic [BYTE_W-1:0]   out_bytes_r, out_bytes_nxt;
  logic [ACT_W-1:0]    out_chunks_r, out_chunks_nxt;

  entry_t              mem [MAX_CHUNKS];
  entry_t              mem_q_r;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  entry_t              mem_wd;

  logic                in_acc, cfg_wr, out_free;
  logic [SIZE_W-1:0]   in_size;
  logic                scan_end, e_fit, e_match, next_ok, sh_done;
  logic [LEN_W-1:0]    rest;
  logic                split, pf, nf;
  logic [CW-1:0]       base;
  logic [1:0]          nrem;
  logic [LEN_W-1:0]    merged;
  logic [HW-1:0]       hdr_pay;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || !out_stall;
  assign in_size  = ({1'b0, in_req_length} + ALIGN_M1) & ~ALIGN_M1;
  assign scan_end = (idx_r == count_r);
  assign hdr_pay  = hdr_r + HDR_H;
  assign e_fit    = !mem_q_r.act && ({2'b00, mem_q_r.len} >= size_r);
  assign e_match  = (hdr_pay == HW'(off_r));
  assign next_ok  = ((idx_r + ONE_C) < count_r);
  assign sh_done  = sh_dn_r ? (sh_src_r >= count_r) : (sh_src_r <= idx_r);
  assign rest     = hit_len_r - size_r[LEN_W-1:0];
  assign split    = rest > HDR_L;
  assign pf       = (idx_r != '0) && !prev_act_r;
  assign nf       = next_free_r;
  assign base     = pf ? (idx_r - ONE_C) : idx_r;
  assign nrem     = {1'b0, pf} + {1'b0, nf};
  assign merged   = hit_len_r + (pf ? (prev_len_r + HDR_L) : '0)
                              + (nf ? (next_len_r + HDR_L) : '0);

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_stat_r;
  assign out_payload_offset = out_off_r;
  assign out_bytes_in_use   = out_bytes_r;
  assign out_chunks_in_use  = out_chunks_r;
  assign pready             = 1'b1;
  assign prdata             = (paddr == 1'b0) ? {31'b0, enable_r} : 32'b0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:     state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_ALLOC && (!enable_r || in_req_length == '0)) state_nxt = ST_DONE;
          else state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_nxt = scan_end ? ST_DONE : ST_SCAN_EX;
      ST_SCAN_EX: begin
        if (cmd_r == CMD_ALLOC) begin
          state_nxt = e_fit ? ST_NEXT_RD : ST_SCAN_RD;
        end else if (e_match) begin
          state_nxt = mem_q_r.act ? ST_NEXT_RD : ST_DONE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_NEXT_RD:  state_nxt = next_ok ? ST_NEXT_EX : ST_FIX;
      ST_NEXT_EX:  state_nxt = ST_FIX;
      ST_FIX:      state_nxt = ST_SHIFT_RD;
      ST_SHIFT_RD: state_nxt = sh_done ? ST_WB1 : ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_WB1:      state_nxt = w2_en_r ? ST_WB2 : ST_DONE;
      ST_WB2:      state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    enable_nxt     = cfg_wr && paddr == 1'b0 ? pwdata[0] : enable_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    count_new_nxt  = count_new_r;
    hdr_nxt        = hdr_r;
    prev_len_nxt   = prev_len_r;
    prev_act_nxt   = prev_act_r;
    hit_len_nxt    = hit_len_r;
    next_free_nxt  = next_free_r;
    next_len_nxt   = next_len_r;
    byte_nxt       = byte_r;
    act_nxt        = act_r;
    stat_nxt       = stat_r;
    res_off_nxt    = res_off_r;
    sh_src_nxt     = sh_src_r;
    sh_dst_nxt     = sh_dst_r;
    sh_dn_nxt      = sh_dn_r;
    w1_addr_nxt    = w1_addr_r;
    w1_data_nxt    = w1_data_r;
    w2_addr_nxt    = w2_addr_r;
    w2_data_nxt    = w2_data_r;
    w2_en_nxt      = w2_en_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_stat_nxt   = out_stat_r;
    out_off_nxt    = out_off_r;
    out_bytes_nxt  = out_bytes_r;
    out_chunks_nxt = out_chunks_r;
    rd_addr        = idx_r[IW-1:0];
    mem_we         = 1'b0;
    mem_wa         = w1_addr_r[IW-1:0];
    mem_wd         = w1_data_r;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = '{len: INIT_LEN, act: 1'b0};
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_cmd;
          size_nxt     = in_size;
          off_nxt      = in_free_offset;
          idx_nxt      = '0;
          hdr_nxt      = '0;
          prev_act_nxt = 1'b1;
          res_off_nxt  = '0;
          stat_nxt     = STAT_ALLOC_FAIL;
        end
      end
      ST_SCAN_RD: begin
        rd_addr = idx_r[IW-1:0];
        if (scan_end) stat_nxt = (cmd_r == CMD_ALLOC) ? STAT_ALLOC_FAIL : STAT_BAD_FREE;
      end
      ST_SCAN_EX: begin
        if ((cmd_r == CMD_ALLOC && e_fit) || (cmd_r == CMD_FREE && e_match)) begin
          hit_len_nxt   = mem_q_r.len;
          next_free_nxt = 1'b0;
          if (cmd_r == CMD_FREE) begin
            if (mem_q_r.act) begin
              byte_nxt = byte_r - BYTE_W'(mem_q_r.len);
              act_nxt  = act_r - ACT_W'(1);
            end else begin
              stat_nxt = STAT_BAD_FREE;
            end
          end
        end else begin
          hdr_nxt      = hdr_r + HDR_H + HW'(mem_q_r.len);
          prev_len_nxt = mem_q_r.len;
          prev_act_nxt = mem_q_r.act;
          idx_nxt      = idx_r + ONE_C;
        end
      end
      ST_NEXT_RD: begin
        rd_addr = idx_r[IW-1:0] + IW'(1);
      end
      ST_NEXT_EX: begin
        next_free_nxt = !mem_q_r.act;
        next_len_nxt  = mem_q_r.len;
      end
      ST_FIX: begin
        stat_nxt      = STAT_OK;
        count_new_nxt = count_r;
        sh_dn_nxt     = 1'b1;
        sh_src_nxt    = count_r;
        w2_en_nxt     = 1'b0;
        w1_addr_nxt   = idx_r;
        if (cmd_r == CMD_ALLOC) begin
          byte_nxt    = byte_r + BYTE_W'(size_r);
          act_nxt     = act_r + ACT_W'(1);
          res_off_nxt = hdr_pay[OFF_W-1:0];
          w1_data_nxt = '{len: hit_len_r, act: 1'b1};
          w2_addr_nxt = idx_r + ONE_C;
          if (split && nf) begin
            w1_data_nxt = '{len: size_r[LEN_W-1:0], act: 1'b1};
            w2_data_nxt = '{len: next_len_r + rest, act: 1'b0};
            w2_en_nxt   = 1'b1;
          end else if (split && count_r < MAXC) begin
            w1_data_nxt   = '{len: size_r[LEN_W-1:0], act: 1'b1};
            w2_data_nxt   = '{len: rest - HDR_L, act: 1'b0};
            w2_en_nxt     = 1'b1;
            sh_dn_nxt     = 1'b0;
            sh_src_nxt    = count_r - ONE_C;
            sh_dst_nxt    = count_r;
            count_new_nxt = count_r + ONE_C;
          end
        end else begin
          w1_addr_nxt   = base;
          w1_data_nxt   = '{len: merged, act: 1'b0};
          count_new_nxt = count_r - CW'(nrem);
          sh_dst_nxt    = base + ONE_C;
          if (nrem != 2'd0) sh_src_nxt = base + ONE_C + CW'(nrem);
        end
      end
      ST_SHIFT_RD: begin
        rd_addr = sh_src_r[IW-1:0];
      end
      ST_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_wa     = sh_dst_r[IW-1:0];
        mem_wd     = mem_q_r;
        sh_src_nxt = sh_dn_r ? sh_src_r + ONE_C : sh_src_r - ONE_C;
        sh_dst_nxt = sh_dn_r ? sh_dst_r + ONE_C : sh_dst_r - ONE_C;
      end
      ST_WB1: begin
        mem_we    = 1'b1;
        mem_wa    = w1_addr_r[IW-1:0];
        mem_wd    = w1_data_r;
        count_nxt = count_new_r;
      end
      ST_WB2: begin
        mem_we = 1'b1;
        mem_wa = w2_addr_r[IW-1:0];
        mem_wd = w2_data_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_stat_nxt   = stat_r;
          out_off_nxt    = (stat_r == STAT_OK) ? res_off_r : '0;
          out_bytes_nxt  = byte_r;
          out_chunks_nxt = act_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      enable_r    <= 1'b1;
      count_r     <= ONE_C;
      byte_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      count_r     <= count_nxt;
      byte_r      <= byte_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    size_r       <= size_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    count_new_r  <= count_new_nxt;
    hdr_r        <= hdr_nxt;
    prev_len_r   <= prev_len_nxt;
    prev_act_r   <= prev_act_nxt;
    hit_len_r    <= hit_len_nxt;
    next_free_r  <= next_free_nxt;
    next_len_r   <= next_len_nxt;
    stat_r       <= stat_nxt;
    res_off_r    <= res_off_nxt;
    sh_src_r     <= sh_src_nxt;
    sh_dst_r     <= sh_dst_nxt;
    sh_dn_r      <= sh_dn_nxt;
    w1_addr_r    <= w1_addr_nxt;
    w1_data_r    <= w1_data_nxt;
    w2_addr_r    <= w2_addr_nxt;
    w2_data_r    <= w2_data_nxt;
    w2_en_r      <= w2_en_nxt;
    out_stat_r   <= out_stat_nxt;
    out_off_r    <= out_off_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_chunks_r <= out_chunks_nxt;
  end

  `AST_IMPL(a_count_range, clk, rst_n, 1'b1, count_r != '0 && count_r <= MAXC)
  `AST_IMPL(a_scan_in_table, clk, rst_n, state_r == ST_SCAN_EX, idx_r < count_r)
  `AST_NEXT(a_done_delivers, clk, rst_n, state_r == ST_DONE && out_free, out_valid_r)
  `AST_IMPL(a_offset_only_ok, clk, rst_n, out_valid_r, out_stat_r == STAT_OK || out_off_r == '0)

endmodule

// ===== sim/ffca_checker.sv =====
// Checker for the chunk allocator: tracks the chunk table, predicts each result and compares
module ffca_checker #(
  parameter int SLAB_BYTES   = ffca_pkg::SLAB_BYTES_DEF,
  parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffca_pkg::ALIGN_BYTES_DEF,
  parameter int MAX_CHUNKS   = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [ffca_pkg::REQ_W-1:0]    in_req_length,
  input  logic [ffca_pkg::OFF_W-1:0]    in_free_offset,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_status,
  input  logic [ffca_pkg::OFF_W-1:0]    out_payload_offset,
  input  logic [ffca_pkg::BYTE_W-1:0]   out_bytes_in_use,
  input  logic [ffca_pkg::ACT_W-1:0]    out_chunks_in_use,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            pending,
  output int                            fail_count
);
  import ffca_pkg::*;

  typedef struct {
    status_t             status;
    logic [OFF_W-1:0]    offset;
    logic [BYTE_W-1:0]   bytes;
    logic [ACT_W-1:0]    chunks;
  } grant_t;

  logic [LEN_W-1:0]  len_tab [MAX_CHUNKS];
  bit                act_tab [MAX_CHUNKS];
  int                n_chunks;
  logic [BYTE_W-1:0] byte_total;
  int                active_total;
  bit                alloc_enable;
  grant_t            grants_due [$];

  function automatic void drop_chunk(int i);
    for (int k = i; k + 1 < n_chunks; k++) begin
      len_tab[k] = len_tab[k+1];
      act_tab[k] = act_tab[k+1];
    end
    n_chunks--;
  endfunction

  function automatic void split_chunk(int i, int len);
    for (int k = n_chunks; k > i; k--) begin
      len_tab[k] = len_tab[k-1];
      act_tab[k] = act_tab[k-1];
    end
    len_tab[i] = len[LEN_W-1:0];
    act_tab[i] = 1'b0;
    n_chunks++;
  endfunction

  function automatic status_t grant_chunk(int req, output logic [OFF_W-1:0] offset);
    int size;
    int hdr;
    int len;
    int rest;
    offset = '0;
    hdr = 0;
    if (!alloc_enable || req == 0) return STAT_ALLOC_FAIL;
    size = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    for (int i = 0; i < n_chunks; i++) begin
      len = len_tab[i];
      if (!act_tab[i] && len >= size) begin
        act_tab[i] = 1'b1;
        if (len - size > HEADER_BYTES) begin
          rest = len - size;
          if (i + 1 < n_chunks && !act_tab[i+1]) begin
            len_tab[i+1] = len_tab[i+1] + rest[LEN_W-1:0];
            len_tab[i] = size[LEN_W-1:0];
          end else if (n_chunks < MAX_CHUNKS) begin
            split_chunk(i + 1, rest - HEADER_BYTES);
            len_tab[i] = size[LEN_W-1:0];
          end
        end
        offset = 16'(hdr + HEADER_BYTES);
        byte_total += 32'(size);
        active_total++;
        return STAT_OK;
      end
      hdr += HEADER_BYTES + len;
    end
    return STAT_ALLOC_FAIL;
  endfunction

  function automatic status_t release_chunk(int off);
    int hdr;
    int i;
    hdr = 0;
    for (i = 0; i < n_chunks; i++) begin
      if (hdr + HEADER_BYTES == off) break;
      hdr += HEADER_BYTES + len_tab[i];
    end
    if (i >= n_chunks || !act_tab[i]) return STAT_BAD_FREE;
    byte_total -= 32'(len_tab[i]);
    active_total--;
    act_tab[i] = 1'b0;
    if (i > 0 && !act_tab[i-1]) begin
      len_tab[i-1] = len_tab[i-1] + 16'(HEADER_BYTES) + len_tab[i];
      drop_chunk(i);
      i--;
    end
    if (i + 1 < n_chunks && !act_tab[i+1]) begin
      len_tab[i] = len_tab[i] + 16'(HEADER_BYTES) + len_tab[i+1];
      drop_chunk(i + 1);
    end
    return STAT_OK;
  endfunction

  function automatic grant_t predict_chunk_op(logic cmd, int req, int off);
    grant_t g;
    logic [OFF_W-1:0] granted;
    granted = '0;
    if (cmd == CMD_ALLOC) g.status = grant_chunk(req, granted);
    else g.status = release_chunk(off);
    g.offset = (g.status == STAT_OK && cmd == CMD_ALLOC) ? granted : '0;
    g.bytes  = byte_total;
    g.chunks = active_total[ACT_W-1:0];
    return g;
  endfunction

  assign pending = grants_due.size();

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      len_tab[0]   = 16'(SLAB_BYTES - HEADER_BYTES);
      act_tab[0]   = 1'b0;
      n_chunks     = 1;
      byte_total   = '0;
      active_total = 0;
      alloc_enable = 1'b1;
      fail_count   <= 0;
      grants_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = grants_due.pop_front();
          if (out_status !== want.status || out_payload_offset !== want.offset ||
              out_bytes_in_use !== want.bytes || out_chunks_in_use !== want.chunks)
            fail_count <= fail_count + 1;
          if (out_status !== want.status)
            $error("status expected %0d got %0d", want.status, out_status);
          if (out_payload_offset !== want.offset)
            $error("payload_offset expected %0d got %0d", want.offset, out_payload_offset);
          if (out_bytes_in_use !== want.bytes)
            $error("bytes_in_use expected %0d got %0d", want.bytes, out_bytes_in_use);
          if (out_chunks_in_use !== want.chunks)
            $error("chunks_in_use expected %0d got %0d", want.chunks, out_chunks_in_use);
        end
      end
      if (in_valid && !in_stall)
        grants_due.push_back(predict_chunk_op(in_cmd, int'(in_req_length),
                                              int'(in_free_offset)));
      if (psel && penable && pwrite && pready && paddr == 1'b0)
        alloc_enable = pwdata[0];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives allocate and free transactions and the enable register, gives the verdict
module tb_top;
  import ffca_pkg::*;

  localparam int CYCLE_LIMIT = 50000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [REQ_W-1:0]   in_req_length;
  logic [OFF_W-1:0]   in_free_offset;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [OFF_W-1:0]   out_payload_offset;
  logic [BYTE_W-1:0]  out_bytes_in_use;
  logic [ACT_W-1:0]   out_chunks_in_use;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 pending;
  int                 fail_count;
  int                 cycles = 0;
  int                 send_gap_pct;
  int                 recv_stall_pct;
  logic [OFF_W-1:0]   live_offsets [$];

  first_fit_chunk_allocator_unit DUT (.*);

  ffca_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall && out_status == STAT_OK && out_payload_offset != 0)
      live_offsets.push_back(out_payload_offset);

  task automatic send_op(logic cmd, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_req_length  <= req;
    in_free_offset <= off;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 1'b0;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic free_live(bit keep);
    int idx;
    logic [OFF_W-1:0] off;
    idx = $urandom_range(live_offsets.size() - 1);
    off = live_offsets[idx];
    if (!keep) live_offsets.delete(idx);
    send_op(CMD_FREE, REQ_W'($urandom), off);
  endtask

  task automatic random_ops(int count);
    int pick;
    logic [REQ_W-1:0] req;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) req = REQ_W'($urandom_range(1, 65536));
      else if (pick < 14) req = REQ_W'($urandom);
      else req = REQ_W'($urandom_range(1, 1024));
      pick = $urandom_range(99);
      if (pick < 35 && live_offsets.size() > 0) free_live(1'b0);
      else if (pick < 38 && live_offsets.size() > 0) free_live(1'b1);
      else if (pick < 45) send_op(CMD_FREE, REQ_W'($urandom), OFF_W'($urandom));
      else if (pick < 47) send_op(CMD_ALLOC, '0, OFF_W'($urandom));
      else send_op(CMD_ALLOC, req, OFF_W'($urandom));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_ALLOC;
    in_req_length  = '0;
    in_free_offset = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 1'b0;
    pwdata         = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(CMD_ALLOC, '0, '0);
    send_op(CMD_ALLOC, 17'd1, '0);
    send_op(CMD_ALLOC, 17'd32, '0);
    send_op(CMD_ALLOC, 17'd33, '0);
    send_op(CMD_ALLOC, 17'd100, '0);
    send_op(CMD_ALLOC, 17'd65536, '0);
    send_op(CMD_ALLOC, 17'h1FFFF, '0);
    send_op(CMD_FREE, '0, 16'd0);
    send_op(CMD_FREE, '0, 16'hFFFF);
    send_op(CMD_FREE, 17'h1FFFF, 16'd12);
    send_op(CMD_FREE, '0, 16'd12);
    send_op(CMD_FREE, '0, 16'd88);
    send_op(CMD_FREE, '0, 16'd56);
    send_op(CMD_ALLOC, 17'd64, '0);
    send_op(CMD_FREE, '0, 16'd200);
    drain();
    write_enable(1'b0);
    send_op(CMD_ALLOC, 17'd32, '0);
    send_op(CMD_FREE, '0, 16'd12);
    drain();
    write_enable(1'b1);
    send_op(CMD_ALLOC, 17'd65500, '0);
    send_op(CMD_ALLOC, 17'd8, '0);
    drain();
    live_offsets.delete();
    send_op(CMD_FREE, '0, 16'd12);
    send_op(CMD_FREE, '0, 16'd44);
    send_op(CMD_FREE, '0, 16'd76);

    send_gap_pct   = 32;
    recv_stall_pct = 50;
    random_ops(170);
    drain();
    write_enable(1'b0);
    send_gap_pct   = 50;
    recv_stall_pct = 32;
    random_ops(20);
    drain();
    write_enable(1'b1);
    random_ops(150);
    drain();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_ops(170);
    drain();

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
